@@ sv/abps_pkg.sv @@
// Package for the alarm buzzer pattern sequencer: codes, widths, pattern ROM.
package abps_pkg;

  localparam int unsigned TICKS_PER_MS    = 10;
  localparam int unsigned MAX_PATTERN_LEN = 40;
  localparam int unsigned ROM_SLOTS       = 20;

  localparam int unsigned TICK_W  = 21;
  localparam int unsigned DELAY_W = 16;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned SIZE_W  = 7;

  localparam logic [TICK_W-1:0]  MUTE_TICKS_RST  = 21'd1200000;
  localparam logic [DELAY_W-1:0] START_DELAY_RST = 16'd100;
  localparam logic [TICK_W-1:0]  TICK_MAX        = {TICK_W{1'b1}};

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_MUTE  = 2'd2,
    OP_STOP  = 2'd3
  } op_t;

  typedef enum logic {
    CFG_MUTE_TICKS  = 1'b0,
    CFG_START_DELAY = 1'b1
  } cfg_idx_t;

  // durations in ms; levels alternate on/off starting with on
  localparam int unsigned ROM_MS [4][ROM_SLOTS] = '{
    '{100, 100, 100, 100, 100, 100, 100, 100, 250, 1000,
      100, 100, 100, 100, 100, 100, 100, 100, 250, 10000},
    '{250, 250, 250, 20000, 0, 0, 0, 0, 0, 0,
      0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{100, 100, 100, 100, 0, 0, 0, 0, 0, 0,
      0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{250, 250, 250, 250, 0, 0, 0, 0, 0, 0,
      0, 0, 0, 0, 0, 0, 0, 0, 0, 0}
  };
  localparam int unsigned ROM_LEN [4] = '{40, 8, 8, 8};
  localparam int unsigned LEN_LIM = MAX_PATTERN_LEN & ~32'd1;

  // pattern length in words, cut to the length limit, at least one pair
  function automatic logic [SIZE_W-1:0] pat_size(logic [1:0] pat);
    int unsigned n;
    n = ROM_LEN[pat];
    if (n > LEN_LIM) n = LEN_LIM;
    if (n < 2) n = 2;
    return SIZE_W'(n);
  endfunction

  // period length in ticks for the pair at idx, saturated to the timer width
  function automatic logic [TICK_W-1:0] dur_ticks(logic [1:0] pat,
                                                   logic [POS_W-1:0] idx);
    logic [4:0]  slot;
    logic [31:0] prod;
    slot = idx[POS_W-1:1];
    if (slot >= 5'(ROM_SLOTS)) slot = slot - 5'(ROM_SLOTS);
    prod = ROM_MS[pat][slot] * TICKS_PER_MS;
    return (prod > 32'(TICK_MAX)) ? TICK_MAX : prod[TICK_W-1:0];
  endfunction

endpackage

@@ sv/abps_in_if.sv @@
// Command channel: tick, start, mute and stop words.
interface abps_in_if import abps_pkg::*;;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [1:0] pattern_select;
  logic       repeat_request;

  modport source (output valid, opcode, pattern_select, repeat_request, input ready);
  modport sink   (input valid, opcode, pattern_select, repeat_request, output ready);
endinterface

@@ sv/abps_out_if.sv @@
// Status channel: one word per accepted command.
interface abps_out_if import abps_pkg::*;;
  logic             valid;
  logic             ready;
  logic             buzzer_drive;
  logic             timer_active;
  logic             is_muted;
  logic [POS_W-1:0] step_position;
  logic             period_expired;

  modport source (output valid, buzzer_drive, timer_active, is_muted, step_position,
                  period_expired, input ready);
  modport sink   (input valid, buzzer_drive, timer_active, is_muted, step_position,
                  period_expired, output ready);
endinterface

@@ sv/abps_cfg_if.sv @@
// Configuration write channel: register index and data.
interface abps_cfg_if import abps_pkg::*;;
  logic              valid;
  logic              ready;
  logic              index;
  logic [TICK_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/alarm_buzzer_pattern_sequencer.sv @@
// Alarm buzzer pattern sequencer: top level with timer, step logic and status register.
//
//   channel  dir  handshake         word
//   in_ch    in   valid/ready       opcode, pattern_select, repeat_request
//   out_ch   out  valid/ready       buzzer_drive, timer_active, is_muted,
//                                   step_position, period_expired
//   cfg_ch   in   valid/ready       index (0 mute_ticks, 1 start_delay_ticks), data
//
// For each command, the state update and the status word are formed
// from the state registers in a single pass and registered together.
// A new command is taken every cycle while the status register is empty or drained.
// A stalled out_ch holds its word; in_ch is held off until the word is taken.
// Reset (rst_n low, synchronous) stops the timer and loads the register defaults.
// cfg_ch is always ready.
module alarm_buzzer_pattern_sequencer import abps_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  abps_in_if.sink      in_ch,
  abps_out_if.source   out_ch,
  abps_cfg_if.sink     cfg_ch
);

  logic [TICK_W-1:0]  mute_ticks_r;
  logic [DELAY_W-1:0] start_delay_r;

  logic               drive_r, drive_nxt;
  logic               running_r, running_nxt;
  logic               muted_r, muted_nxt;
  logic               repeat_r, repeat_nxt;
  logic               begun_r, begun_nxt;
  logic [1:0]         pattern_r, pattern_nxt;
  logic [POS_W-1:0]   pair_r, pair_nxt;
  logic [TICK_W-1:0]  elapsed_r, elapsed_nxt;
  logic [TICK_W-1:0]  period_r, period_nxt;
  logic               expired_nxt;

  logic               out_valid_r;
  logic               in_fire;
  op_t                op;

  logic [SIZE_W-1:0]  size;
  logic [TICK_W-1:0]  elapsed_inc;
  logic [POS_W-1:0]   idx;
  logic [SIZE_W-1:0]  idx_adv;
  logic [POS_W-1:0]   dur_idx;
  logic [TICK_W-1:0]  dur;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign op           = op_t'(in_ch.opcode);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mute_ticks_r  <= MUTE_TICKS_RST;
      start_delay_r <= START_DELAY_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        CFG_MUTE_TICKS:  mute_ticks_r  <= cfg_ch.data;
        CFG_START_DELAY: start_delay_r <= cfg_ch.data[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // step lookup for the current pattern
  always_comb begin
    size        = pat_size(pattern_r);
    elapsed_inc = elapsed_r + 1'b1;
    idx         = ((SIZE_W'(pair_r) + 1'b1) >= size) ? '0 : pair_r;
    idx_adv     = SIZE_W'(idx) + SIZE_W'(2);
    dur_idx     = muted_r ? '0 : idx;
    dur         = dur_ticks(pattern_r, dur_idx);
  end

  always_comb begin
    drive_nxt   = drive_r;
    running_nxt = running_r;
    muted_nxt   = muted_r;
    repeat_nxt  = repeat_r;
    begun_nxt   = begun_r;
    pattern_nxt = pattern_r;
    pair_nxt    = pair_r;
    elapsed_nxt = elapsed_r;
    period_nxt  = period_r;
    expired_nxt = 1'b0;
    unique case (op)
      OP_TICK: begin
        if (running_r) begin
          if (elapsed_inc >= period_r) begin
            elapsed_nxt = '0;
            expired_nxt = 1'b1;
            if (muted_r) begin
              // mute over: wait one first-step duration silent, then replay
              muted_nxt  = 1'b0;
              pair_nxt   = '0;
              period_nxt = dur;
            end else if (idx == '0 && !repeat_r && begun_r) begin
              running_nxt = 1'b0;
              drive_nxt   = 1'b0;
            end else begin
              drive_nxt  = !idx[1];
              period_nxt = dur;
              pair_nxt   = (idx_adv >= size) ? '0 : idx_adv[POS_W-1:0];
              begun_nxt  = 1'b1;
            end
          end else begin
            elapsed_nxt = elapsed_inc;
          end
        end
      end
      OP_START: begin
        elapsed_nxt = '0;
        pattern_nxt = in_ch.pattern_select;
        pair_nxt    = '0;
        repeat_nxt  = in_ch.repeat_request;
        begun_nxt   = 1'b0;
        muted_nxt   = 1'b0;
        period_nxt  = TICK_W'(start_delay_r);
        running_nxt = 1'b1;
      end
      OP_MUTE: begin
        if (repeat_r && !muted_r) begin
          muted_nxt   = 1'b1;
          elapsed_nxt = '0;
          pair_nxt    = '0;
          drive_nxt   = 1'b0;
          period_nxt  = mute_ticks_r;
          running_nxt = 1'b1;
        end
      end
      OP_STOP: begin
        repeat_nxt  = 1'b0;
        drive_nxt   = 1'b0;
        running_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_r   <= 1'b0;
      running_r <= 1'b0;
      muted_r   <= 1'b0;
      repeat_r  <= 1'b0;
      begun_r   <= 1'b0;
      pattern_r <= '0;
      pair_r    <= '0;
      elapsed_r <= '0;
      period_r  <= TICK_W'(1);
    end else if (in_fire) begin
      drive_r   <= drive_nxt;
      running_r <= running_nxt;
      muted_r   <= muted_nxt;
      repeat_r  <= repeat_nxt;
      begun_r   <= begun_nxt;
      pattern_r <= pattern_nxt;
      pair_r    <= pair_nxt;
      elapsed_r <= elapsed_nxt;
      period_r  <= period_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // status word: state after this command
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_ch.buzzer_drive   <= drive_nxt;
      out_ch.timer_active   <= running_nxt;
      out_ch.is_muted       <= muted_nxt;
      out_ch.step_position  <= pair_nxt;
      out_ch.period_expired <= expired_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;

  a_pair_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !pair_r[0] && (SIZE_W'(pair_r) < size))
    else $error("step index odd or beyond pattern length");

  a_fire_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted command produced no status word");

  a_expiry_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (op != OP_TICK || !running_r)) |=> !out_ch.period_expired)
    else $error("period expiry reported without a running tick");

  a_stop_silences: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && op == OP_STOP) |=> (!drive_r && !running_r))
    else $error("stop left buzzer or timer active");

endmodule

@@ dv/tb_alarm_buzzer_pattern_sequencer.sv @@
// Testbench for the alarm buzzer pattern sequencer: random commands, status prediction, checks.
module tb_alarm_buzzer_pattern_sequencer;
  import abps_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned REPORT_CAP     = 40;

  // tone table in ms; level alternates on/off starting with on
  localparam int unsigned TONE_MS [4][ROM_SLOTS] = '{
    '{100, 100, 100, 100, 100, 100, 100, 100, 250, 1000,
      100, 100, 100, 100, 100, 100, 100, 100, 250, 10000},
    '{250, 250, 250, 20000, 0, 0, 0, 0, 0, 0,
      0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{100, 100, 100, 100, 0, 0, 0, 0, 0, 0,
      0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{250, 250, 250, 250, 0, 0, 0, 0, 0, 0,
      0, 0, 0, 0, 0, 0, 0, 0, 0, 0}
  };
  localparam int unsigned TONE_LEN [4] = '{40, 8, 8, 8};

  typedef struct {
    op_t         op;
    logic [1:0]  pat;
    logic        rep;
    int unsigned gap;
  } cmd_word_t;

  typedef struct {
    logic             buzz;
    logic             active;
    logic             muted;
    logic [POS_W-1:0] pos;
    logic             expired;
  } status_word_t;

  logic clk;
  logic rst_n;

  abps_in_if  cmd_if ();
  abps_out_if stat_if ();
  abps_cfg_if cfg_if ();

  alarm_buzzer_pattern_sequencer u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cmd_if),
    .out_ch (stat_if),
    .cfg_ch (cfg_if)
  );

  // sequencer state as predicted, reset values
  logic              buzz_lvl   = 1'b0;
  logic              timer_on   = 1'b0;
  logic              mute_on    = 1'b0;
  logic              loop_on    = 1'b0;
  logic              started    = 1'b0;
  logic [1:0]        pat_sel    = 2'd0;
  logic [POS_W-1:0]  step_pos   = '0;
  logic [TICK_W-1:0] tick_cnt   = '0;
  logic [TICK_W-1:0] period_len = TICK_W'(1);
  logic [TICK_W-1:0] mute_len   = MUTE_TICKS_RST;
  logic [DELAY_W-1:0] delay_len = START_DELAY_RST;

  cmd_word_t    pending_cmds [$];
  status_word_t status_due [$];
  cmd_word_t    held_cmd;
  bit           have_held    = 1'b0;
  int unsigned  gap_left     = 0;
  logic         cmd_taken    = 1'b0;
  int unsigned  stall_left   = 0;
  bit           out_calm     = 1'b0;
  int unsigned  idle_cycles  = 0;
  int unsigned  errors       = 0;

  always #5 clk = ~clk;

  function automatic int unsigned words_in(logic [1:0] p);
    int unsigned n;
    n = TONE_LEN[p];
    if (n > (MAX_PATTERN_LEN / 2) * 2) n = (MAX_PATTERN_LEN / 2) * 2;
    if (n < 2) n = 2;
    return n;
  endfunction

  function automatic logic [TICK_W-1:0] step_ticks(logic [1:0] p, int unsigned idx);
    longint unsigned t;
    t = longint'(TONE_MS[p][(idx / 2) % ROM_SLOTS]) * TICKS_PER_MS;
    if (t > TICK_MAX) return TICK_MAX;
    return t[TICK_W-1:0];
  endfunction

  // period ran out: leave the mute, halt a one-shot pattern, or apply the next pair
  function automatic void close_period();
    int unsigned size;
    int unsigned idx;
    size = words_in(pat_sel);
    idx  = step_pos;
    if (idx + 1 >= size) idx = 0;
    if (mute_on) begin
      mute_on    = 1'b0;
      step_pos   = '0;
      period_len = step_ticks(pat_sel, 0);
    end else if (idx == 0 && !loop_on && started) begin
      timer_on = 1'b0;
      buzz_lvl = 1'b0;
    end else begin
      buzz_lvl   = ((idx / 2) % 2) == 0;
      period_len = step_ticks(pat_sel, idx);
      idx        = idx + 2;
      if (idx >= size) idx = 0;
      step_pos   = idx[POS_W-1:0];
      started    = 1'b1;
    end
  endfunction

  function automatic status_word_t next_status(op_t op, logic [1:0] pat, logic rep);
    status_word_t s;
    s.expired = 1'b0;
    case (op)
      OP_TICK: begin
        if (timer_on) begin
          tick_cnt = tick_cnt + 1'b1;
          if (tick_cnt >= period_len) begin
            tick_cnt  = '0;
            s.expired = 1'b1;
            close_period();
          end
        end
      end
      OP_START: begin
        tick_cnt   = '0;
        pat_sel    = pat;
        step_pos   = '0;
        loop_on    = rep;
        started    = 1'b0;
        mute_on    = 1'b0;
        period_len = TICK_W'(delay_len);
        timer_on   = 1'b1;
      end
      OP_MUTE: begin
        if (loop_on && !mute_on) begin
          mute_on    = 1'b1;
          tick_cnt   = '0;
          step_pos   = '0;
          buzz_lvl   = 1'b0;
          period_len = mute_len;
          timer_on   = 1'b1;
        end
      end
      default: begin
        loop_on  = 1'b0;
        buzz_lvl = 1'b0;
        timer_on = 1'b0;
      end
    endcase
    s.buzz   = buzz_lvl;
    s.active = timer_on;
    s.muted  = mute_on;
    s.pos    = step_pos;
    return s;
  endfunction

  function automatic void check_field(string name, logic [POS_W-1:0] want,
                                      logic [POS_W-1:0] got);
    if (got !== want) begin
      if (errors < REPORT_CAP) $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  function automatic int unsigned pick_gap(bit busy);
    int unsigned r;
    r = $urandom_range(999, 0);
    if (busy) return (r < 985) ? 0 : (r < 998) ? $urandom_range(3, 1) : $urandom_range(40, 4);
    return (r < 700) ? 0 : (r < 950) ? $urandom_range(3, 1) : $urandom_range(40, 4);
  endfunction

  task automatic push_cmd(op_t op, logic [1:0] pat, logic rep, bit busy);
    cmd_word_t w;
    w.op  = op;
    w.pat = pat;
    w.rep = rep;
    w.gap = pick_gap(busy);
    pending_cmds.push_back(w);
  endtask

  // ticks carry random junk in the fields that only start uses
  task automatic push_ticks(int unsigned n, bit busy);
    for (int unsigned k = 0; k < n; k++)
      push_cmd(OP_TICK, 2'($urandom_range(3, 0)), 1'($urandom_range(1, 0)), busy);
  endtask

  task automatic add_long_play(logic [1:0] pat, logic rep, int unsigned n);
    push_cmd(OP_START, pat, rep, 1'b1);
    push_ticks(n, 1'b1);
  endtask

  // start (now and then another random command), then a run of ticks with commands sprinkled in
  task automatic add_sessions(int unsigned target);
    int unsigned n;
    int unsigned len;
    n = 0;
    while (n < target) begin
      if ($urandom_range(99, 0) < 85)
        push_cmd(OP_START, 2'($urandom_range(3, 0)), $urandom_range(99, 0) < 65, 1'b0);
      else
        push_cmd(op_t'($urandom_range(3, 0)), 2'($urandom_range(3, 0)),
                 1'($urandom_range(1, 0)), 1'b0);
      len = ($urandom_range(99, 0) < 75) ? $urandom_range(24, 1) : $urandom_range(300, 25);
      for (int unsigned k = 0; k < len; k++) begin
        if ($urandom_range(99, 0) < 5)
          push_cmd(($urandom_range(99, 0) < 60) ? OP_MUTE : op_t'($urandom_range(3, 0)),
                   2'($urandom_range(3, 0)), 1'($urandom_range(1, 0)), 1'b0);
        else
          push_ticks(1, 1'b0);
      end
      n = n + len + 1;
    end
  endtask

  // hold until every queued command went in and every status word came back
  task automatic wait_idle();
    while (pending_cmds.size() != 0 || have_held || cmd_if.valid || status_due.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [TICK_W-1:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    if (idx == CFG_MUTE_TICKS) mute_len = value;
    else delay_len = value[DELAY_W-1:0];
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // command driver
  always @(negedge clk) begin
    if (!rst_n) begin
      cmd_if.valid <= 1'b0;
    end else if (!cmd_if.valid || cmd_taken) begin
      if (!have_held && pending_cmds.size() != 0) begin
        held_cmd  = pending_cmds.pop_front();
        have_held = 1'b1;
        gap_left  = held_cmd.gap;
      end
      if (have_held && gap_left == 0) begin
        cmd_if.valid          <= 1'b1;
        cmd_if.opcode         <= held_cmd.op;
        cmd_if.pattern_select <= held_cmd.pat;
        cmd_if.repeat_request <= held_cmd.rep;
        have_held = 1'b0;
      end else begin
        cmd_if.valid <= 1'b0;
        if (gap_left != 0) gap_left--;
      end
    end
  end

  // status backpressure: short stalls mostly, a few long ones, calm stretches
  always @(negedge clk) begin
    if ($urandom_range(999, 0) == 0) out_calm = !out_calm;
    if (stall_left != 0) begin
      stall_left--;
      stat_if.ready <= 1'b0;
    end else if (!out_calm && $urandom_range(99, 0) < 12) begin
      stall_left = ($urandom_range(9, 0) == 0) ? $urandom_range(39, 4) : $urandom_range(1, 0);
      stat_if.ready <= 1'b0;
    end else begin
      stat_if.ready <= 1'b1;
    end
  end

  // predict on every accepted command, check every accepted status word
  always @(posedge clk) begin
    status_word_t want;
    if (!rst_n) begin
      cmd_taken <= 1'b0;
    end else begin
      cmd_taken <= cmd_if.valid && cmd_if.ready;
      if (cmd_if.valid && cmd_if.ready)
        status_due.push_back(next_status(op_t'(cmd_if.opcode), cmd_if.pattern_select,
                                         cmd_if.repeat_request));
      if (stat_if.valid && stat_if.ready) begin
        if (status_due.size() == 0) begin
          if (errors < REPORT_CAP) $error("status word with no command pending");
          errors++;
        end else begin
          want = status_due.pop_front();
          check_field("buzzer_drive", POS_W'(want.buzz), POS_W'(stat_if.buzzer_drive));
          check_field("timer_active", POS_W'(want.active), POS_W'(stat_if.timer_active));
          check_field("is_muted", POS_W'(want.muted), POS_W'(stat_if.is_muted));
          check_field("step_position", want.pos, stat_if.step_position);
          check_field("period_expired", POS_W'(want.expired), POS_W'(stat_if.period_expired));
        end
      end
    end
  end

  // end the run when no word moves on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (cmd_if.valid && cmd_if.ready) || (stat_if.valid && stat_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clk                   = 1'b0;
    rst_n                 = 1'b0;
    cmd_if.valid          = 1'b0;
    cmd_if.opcode         = OP_TICK;
    cmd_if.pattern_select = 2'd0;
    cmd_if.repeat_request = 1'b0;
    stat_if.ready         = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = CFG_MUTE_TICKS;
    cfg_if.data           = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: commands while stopped, double mute, stop keeps the mute flag
    push_cmd(OP_TICK, 2'd3, 1'b1, 1'b0);
    push_cmd(OP_MUTE, 2'd0, 1'b1, 1'b0);
    push_cmd(OP_STOP, 2'd2, 1'b0, 1'b0);
    push_cmd(OP_START, 2'd3, 1'b1, 1'b0);
    push_cmd(OP_MUTE, 2'd1, 1'b0, 1'b0);
    push_cmd(OP_MUTE, 2'd2, 1'b1, 1'b0);
    push_ticks(1, 1'b0);
    push_cmd(OP_STOP, 2'd3, 1'b1, 1'b0);
    push_ticks(1, 1'b0);
    wait_idle();

    // shortest settings: expiry on the first tick after start and after mute
    write_reg(CFG_MUTE_TICKS, TICK_W'(1));
    write_reg(CFG_START_DELAY, {5'($urandom_range(31, 0)), 16'd1});
    push_cmd(OP_START, 2'd0, 1'b0, 1'b0);
    push_ticks(1, 1'b0);
    push_cmd(OP_MUTE, 2'd3, 1'b1, 1'b0);
    push_cmd(OP_START, 2'd2, 1'b1, 1'b0);
    push_ticks(1, 1'b0);
    push_cmd(OP_MUTE, 2'd0, 1'b0, 1'b0);
    push_ticks(1, 1'b0);
    push_cmd(OP_MUTE, 2'd1, 1'b1, 1'b0);
    push_ticks(2, 1'b0);
    push_cmd(OP_START, 2'd1, 1'b0, 1'b0);
    push_cmd(OP_STOP, 2'd0, 1'b0, 1'b0);
    push_ticks(1, 1'b0);
    add_sessions(180);
    // one-shot plays: the first pair applies on the first tick after start
    add_long_play(2'd0, 1'b0, 60);
    add_long_play(2'd3, 1'b0, 40);
    wait_idle();

    write_reg(CFG_MUTE_TICKS, TICK_W'($urandom_range(60, 2)));
    write_reg(CFG_START_DELAY, {5'($urandom_range(31, 0)), 16'($urandom_range(20, 2))});
    add_long_play(2'd2, 1'b1, 200);
    push_cmd(OP_MUTE, 2'd0, 1'b0, 1'b1);
    push_ticks(100, 1'b1);
    push_cmd(OP_STOP, 2'd1, 1'b1, 1'b0);
    add_sessions(80);
    wait_idle();
    add_sessions(80);
    wait_idle();

    // longest settings: the timer counts but never reaches expiry here
    write_reg(CFG_MUTE_TICKS, TICK_MAX);
    write_reg(CFG_START_DELAY, {5'($urandom_range(31, 0)), 16'hFFFF});
    add_sessions(100);
    wait_idle();

    write_reg(CFG_START_DELAY, {5'($urandom_range(31, 0)), 16'($urandom_range(300, 1))});
    write_reg(CFG_MUTE_TICKS, TICK_W'($urandom_range(2000, 1)));
    add_long_play(2'd1, 1'b1, 100);
    push_cmd(OP_STOP, 2'd2, 1'b0, 1'b0);
    add_sessions(100);
    wait_idle();
    repeat (8) @(posedge clk);

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
